// ===== src/lss_pkg.sv =====
package lss_pkg;

   localparam int SCAN_SAMPLES = 2000;
   localparam int IDX_W        = 11;
   localparam int RANGE_W      = 16;
   localparam int SPEED_W      = 8;
   localparam int CSR_IDX_W    = 3;

   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

   // wall windows
   localparam logic [IDX_W-1:0] LEFT_A_HI  = IDX_W'(46);
   localparam logic [IDX_W-1:0] LEFT_B_LO  = IDX_W'(1825);
   localparam logic [IDX_W-1:0] LEFT_B_HI  = IDX_W'(1976);
   localparam logic [IDX_W-1:0] FRONT_LO   = IDX_W'(1189);
   localparam logic [IDX_W-1:0] FRONT_HI   = IDX_W'(1549);
   localparam logic [IDX_W-1:0] RIGHT_LO   = IDX_W'(824);
   localparam logic [IDX_W-1:0] RIGHT_HI   = IDX_W'(876);

   // crash sectors
   localparam logic [IDX_W-1:0] EDGE_A_HI  = IDX_W'(47);
   localparam logic [IDX_W-1:0] WIDE_HI    = IDX_W'(582);
   localparam logic [IDX_W-1:0] SIDE_HI    = IDX_W'(912);
   localparam logic [IDX_W-1:0] NEAR_HI    = IDX_W'(1802);
   localparam logic [IDX_W-1:0] SCAN_LAST  = IDX_W'(SCAN_SAMPLES - 1);

   // probes
   localparam logic [IDX_W-1:0] RIGHT_PROBE_IDX = IDX_W'(820);
   localparam logic [IDX_W-1:0] LEFT_PROBE_IDX  = IDX_W'(1890);

   // recovery quadrants
   localparam logic [IDX_W-1:0] BACK_LO    = IDX_W'(1890);
   localparam logic [IDX_W-1:0] BACK_HI    = IDX_W'(SCAN_SAMPLES);
   localparam logic [IDX_W-1:0] BACK_LOW_HI = IDX_W'(820);
   localparam logic [IDX_W-1:0] RSIDE_LO   = IDX_W'(300);
   localparam logic [IDX_W-1:0] RSIDE_HI   = IDX_W'(1361);

   // wall flag bits
   localparam int WALL_LEFT  = 0;
   localparam int WALL_FRONT = 1;
   localparam int WALL_RIGHT = 2;

   // speeds in hundredths
   localparam logic signed [SPEED_W-1:0] V_FULL_POS  = SPEED_W'(100);
   localparam logic signed [SPEED_W-1:0] V_FULL_NEG  = -SPEED_W'(100);
   localparam logic signed [SPEED_W-1:0] V_CRUISE    = SPEED_W'(50);
   localparam logic signed [SPEED_W-1:0] V_SLOW      = SPEED_W'(30);
   localparam logic signed [SPEED_W-1:0] V_ZERO      = SPEED_W'(0);
   localparam logic signed [SPEED_W-1:0] W_OPEN      = -SPEED_W'(77);
   localparam logic signed [SPEED_W-1:0] W_LEFT_WALL = -SPEED_W'(65);
   localparam logic signed [SPEED_W-1:0] W_FRONT     = SPEED_W'(50);

   // queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WALL_THRESHOLD = 3'd0,
      REG_SIDE_CLOSE     = 3'd1,
      REG_CRASH_WIDE     = 3'd2,
      REG_CRASH_EDGE     = 3'd3,
      REG_CRASH_SIDE     = 3'd4,
      REG_CRASH_NEAR     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] wall_threshold_mm;
      logic [RANGE_W-1:0] side_close_mm;
      logic [RANGE_W-1:0] crash_wide_mm;
      logic [RANGE_W-1:0] crash_edge_mm;
      logic [RANGE_W-1:0] crash_side_mm;
      logic [RANGE_W-1:0] crash_near_mm;
   } cfg_type;

   // one finished scan, as handed from front to back
   typedef struct packed {
      logic             crash;
      logic [2:0]       walls;
      logic             right_close;
      logic             left_close;
      logic [IDX_W-1:0] min_position;
   } summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/lidar_sector_steering.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------
// req_     | in        | req_valid / req_stall | range_mm, end_of_scan
// rsp_     | out       | rsp_valid / rsp_stall | linear_speed, turn_rate, crash_seen,
//          |           |                       | nearest_index, last_result
// csr_     | in        | csr_valid / csr_ready | index, wdata (ready always high)
//
// One sample is taken each cycle while req_stall is low; all per-sample compares
// and the running minimum sit in a single front stage. An end-of-scan beat pushes
// a scan summary into a two-entry queue; the back end registers its result beats.
// With rsp_stall low it gives one beat a cycle: two for a crash scan, else one.
// req_stall rises only while the queue is full. Reset is synchronous and clears
// scan state, queue and output valid; registers return to their reset values.
module lidar_sector_steering (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lss_pkg::RANGE_W-1:0]        req_range_mm,
   input  logic                               req_end_of_scan,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lss_pkg::SPEED_W-1:0] rsp_linear_speed,
   output logic signed [lss_pkg::SPEED_W-1:0] rsp_turn_rate,
   output logic                               rsp_crash_seen,
   output logic [lss_pkg::IDX_W-1:0]          rsp_nearest_index,
   output logic                               rsp_last_result,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lss_pkg::RANGE_W-1:0]        csr_wdata
);

   lss_pkg::cfg_type           cfg_ff;
   lss_pkg::queue_status_type  q_status;
   lss_pkg::summary_type       push_data;
   lss_pkg::summary_type       pop_data;
   logic                       q_push;
   logic                       q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wall_threshold_mm <= lss_pkg::RANGE_W'(550);
         cfg_ff.side_close_mm     <= lss_pkg::RANGE_W'(250);
         cfg_ff.crash_wide_mm     <= lss_pkg::RANGE_W'(300);
         cfg_ff.crash_edge_mm     <= lss_pkg::RANGE_W'(250);
         cfg_ff.crash_side_mm     <= lss_pkg::RANGE_W'(240);
         cfg_ff.crash_near_mm     <= lss_pkg::RANGE_W'(200);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lss_pkg::REG_WALL_THRESHOLD: cfg_ff.wall_threshold_mm <= csr_wdata;
            lss_pkg::REG_SIDE_CLOSE:     cfg_ff.side_close_mm     <= csr_wdata;
            lss_pkg::REG_CRASH_WIDE:     cfg_ff.crash_wide_mm     <= csr_wdata;
            lss_pkg::REG_CRASH_EDGE:     cfg_ff.crash_edge_mm     <= csr_wdata;
            lss_pkg::REG_CRASH_SIDE:     cfg_ff.crash_side_mm     <= csr_wdata;
            lss_pkg::REG_CRASH_NEAR:     cfg_ff.crash_near_mm     <= csr_wdata;
            default:                     cfg_ff <= cfg_ff;
         endcase
      end
   end

   lss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_range_mm    (req_range_mm),
      .req_end_of_scan (req_end_of_scan),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   lss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   lss_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_data            (pop_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_crash_seen    (rsp_crash_seen),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

// ===== src/lss_front.sv =====
module lss_front (
   input  logic                           clock,
   input  logic                           reset,
   input  lss_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lss_pkg::RANGE_W-1:0]    req_range_mm,
   input  logic                           req_end_of_scan,
   input  lss_pkg::queue_status_type      q_status,
   output logic                           q_push,
   output lss_pkg::summary_type           q_data
);

   logic [lss_pkg::IDX_W-1:0]   count_ff, count_in;
   logic [2:0]                  walls_ff, walls_in;
   logic                        crash_ff, crash_in;
   logic [lss_pkg::RANGE_W-1:0] min_ff, min_in;
   logic [lss_pkg::IDX_W-1:0]   minpos_ff, minpos_in;
   logic [lss_pkg::RANGE_W-1:0] rprobe_ff, rprobe_in;
   logic [lss_pkg::RANGE_W-1:0] lprobe_ff, lprobe_in;
   logic [lss_pkg::RANGE_W-1:0] thr;
   logic                        thr_valid;
   logic                        below_wall;
   logic                        accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && req_end_of_scan;

   always_comb begin
      below_wall = req_range_mm < cfg.wall_threshold_mm;
      walls_in   = walls_ff;
      if (below_wall) begin
         if (count_ff <= lss_pkg::LEFT_A_HI ||
             (count_ff >= lss_pkg::LEFT_B_LO && count_ff <= lss_pkg::LEFT_B_HI)) begin
            walls_in[lss_pkg::WALL_LEFT] = 1'b1;
         end
         if (count_ff >= lss_pkg::FRONT_LO && count_ff <= lss_pkg::FRONT_HI) begin
            walls_in[lss_pkg::WALL_FRONT] = 1'b1;
         end
         if (count_ff >= lss_pkg::RIGHT_LO && count_ff <= lss_pkg::RIGHT_HI) begin
            walls_in[lss_pkg::WALL_RIGHT] = 1'b1;
         end
      end

      // sector threshold; sample 0 and samples past the scan length never crash
      thr       = '0;
      thr_valid = 1'b1;
      priority if (count_ff == '0) begin
         thr_valid = 1'b0;
      end else if (count_ff <= lss_pkg::EDGE_A_HI) begin
         thr = cfg.crash_edge_mm;
      end else if (count_ff <= lss_pkg::WIDE_HI) begin
         thr = cfg.crash_wide_mm;
      end else if (count_ff <= lss_pkg::SIDE_HI) begin
         thr = cfg.crash_side_mm;
      end else if (count_ff <= lss_pkg::NEAR_HI) begin
         thr = cfg.crash_near_mm;
      end else if (count_ff <= lss_pkg::SCAN_LAST) begin
         thr = cfg.crash_edge_mm;
      end else begin
         thr_valid = 1'b0;
      end
      crash_in = crash_ff || (thr_valid && req_range_mm < thr);

      // first minimum wins
      if (count_ff == '0 || req_range_mm < min_ff) begin
         min_in    = req_range_mm;
         minpos_in = count_ff;
      end else begin
         min_in    = min_ff;
         minpos_in = minpos_ff;
      end

      rprobe_in = (count_ff == lss_pkg::RIGHT_PROBE_IDX) ? req_range_mm : rprobe_ff;
      lprobe_in = (count_ff == lss_pkg::LEFT_PROBE_IDX) ? req_range_mm : lprobe_ff;
      count_in  = (count_ff != lss_pkg::IDX_MAX) ? count_ff + 1'b1 : count_ff;

      q_data.crash        = crash_in;
      q_data.walls        = walls_in;
      q_data.right_close  = rprobe_in < cfg.side_close_mm;
      q_data.left_close   = lprobe_in < cfg.side_close_mm;
      q_data.min_position = minpos_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_scan)) begin
         count_ff  <= '0;
         walls_ff  <= '0;
         crash_ff  <= 1'b0;
         min_ff    <= '1;
         minpos_ff <= '0;
         rprobe_ff <= '1;
         lprobe_ff <= '1;
      end else if (accept) begin
         count_ff  <= count_in;
         walls_ff  <= walls_in;
         crash_ff  <= crash_in;
         min_ff    <= min_in;
         minpos_ff <= minpos_in;
         rprobe_ff <= rprobe_in;
         lprobe_ff <= lprobe_in;
      end
   end

endmodule

// ===== src/lss_queue.sv =====
module lss_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lss_pkg::summary_type        push_data,
   input  logic                        pop,
   output lss_pkg::summary_type        pop_data,
   output lss_pkg::queue_status_type   status
);

   lss_pkg::summary_type                 store_ff [lss_pkg::QUEUE_DEPTH];
   logic [lss_pkg::QUEUE_AW-1:0]         wr_ptr_ff;
   logic [lss_pkg::QUEUE_AW-1:0]         rd_ptr_ff;
   logic [lss_pkg::QUEUE_CW-1:0]         count_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign status.full  = count_ff == lss_pkg::QUEUE_CW'(lss_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== src/lss_back.sv =====
module lss_back (
   input  logic                               clock,
   input  logic                               reset,
   input  lss_pkg::queue_status_type          q_status,
   input  lss_pkg::summary_type               q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lss_pkg::SPEED_W-1:0] rsp_linear_speed,
   output logic signed [lss_pkg::SPEED_W-1:0] rsp_turn_rate,
   output logic                               rsp_crash_seen,
   output logic [lss_pkg::IDX_W-1:0]          rsp_nearest_index,
   output logic                               rsp_last_result
);

   logic                               valid_ff;
   logic                               recover_sent_ff;
   logic signed [lss_pkg::SPEED_W-1:0] lin_ff, lin_in;
   logic signed [lss_pkg::SPEED_W-1:0] turn_ff, turn_in;
   logic                               crash_ff;
   logic [lss_pkg::IDX_W-1:0]          nearest_ff;
   logic                               last_ff, last_in;
   logic                               load;
   logic                               back_q, right_q;

   assign load = (!valid_ff || !rsp_stall) && !q_status.empty;
   // a crash scan stays queued until its stop beat is loaded
   assign q_pop = load && (!q_data.crash || recover_sent_ff);

   always_comb begin
      back_q = (q_data.min_position >= lss_pkg::BACK_LO &&
                q_data.min_position <= lss_pkg::BACK_HI) ||
               q_data.min_position <= lss_pkg::BACK_LOW_HI;
      right_q = q_data.min_position >= lss_pkg::RSIDE_LO &&
                q_data.min_position <= lss_pkg::RSIDE_HI;
      lin_in  = lss_pkg::V_ZERO;
      turn_in = lss_pkg::V_ZERO;
      last_in = 1'b1;
      if (q_data.crash) begin
         if (!recover_sent_ff) begin
            lin_in  = back_q ? lss_pkg::V_FULL_POS : lss_pkg::V_FULL_NEG;
            turn_in = right_q ? lss_pkg::V_FULL_POS : lss_pkg::V_FULL_NEG;
            last_in = 1'b0;
         end
      end else begin
         unique case (q_data.walls)
            3'b000: begin
               lin_in  = lss_pkg::V_CRUISE;
               turn_in = lss_pkg::W_OPEN;
            end
            3'b001: begin
               lin_in  = lss_pkg::V_CRUISE;
               turn_in = lss_pkg::W_LEFT_WALL;
            end
            3'b100, 3'b101: begin
               lin_in  = lss_pkg::V_CRUISE;
               turn_in = lss_pkg::V_ZERO;
            end
            default: begin
               lin_in  = lss_pkg::V_ZERO;
               turn_in = lss_pkg::W_FRONT;
            end
         endcase
         // left probe wins when both are close
         priority if (q_data.left_close) begin
            lin_in  = lss_pkg::V_SLOW;
            turn_in = lss_pkg::V_FULL_NEG;
         end else if (q_data.right_close) begin
            lin_in  = lss_pkg::V_SLOW;
            turn_in = lss_pkg::V_FULL_POS;
         end else begin
            lin_in  = lin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         recover_sent_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= !q_status.empty;
         if (load) begin
            recover_sent_ff <= q_data.crash && !recover_sent_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lin_ff     <= lin_in;
         turn_ff    <= turn_in;
         crash_ff   <= q_data.crash;
         nearest_ff <= q_data.min_position;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_linear_speed  = lin_ff;
   assign rsp_turn_rate     = turn_ff;
   assign rsp_crash_seen    = crash_ff;
   assign rsp_nearest_index = nearest_ff;
   assign rsp_last_result   = last_ff;

endmodule

// ===== src/lss_checker.sv =====
module lss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [lss_pkg::SPEED_W-1:0] rsp_linear_speed,
   input logic signed [lss_pkg::SPEED_W-1:0] rsp_turn_rate,
   input logic                               rsp_crash_seen,
   input logic [lss_pkg::IDX_W-1:0]          rsp_nearest_index,
   input logic                               rsp_last_result
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_linear_speed) &&
         $stable(rsp_turn_rate) && $stable(rsp_crash_seen) &&
         $stable(rsp_nearest_index) && $stable(rsp_last_result))
      else $error("result beat changed under stall");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crash_seen |-> rsp_last_result)
      else $error("non-crash scan gave more than one beat");

   // recovery beat is always followed by the stop beat of the same scan
   a_recover_then_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_crash_seen && !rsp_last_result |=>
         rsp_valid && rsp_crash_seen && rsp_last_result &&
         rsp_linear_speed == lss_pkg::V_ZERO && rsp_turn_rate == lss_pkg::V_ZERO &&
         $stable(rsp_nearest_index))
      else $error("recovery beat not followed by stop");

   a_recover_speeds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crash_seen && !rsp_last_result |->
         (rsp_linear_speed == lss_pkg::V_FULL_POS ||
          rsp_linear_speed == lss_pkg::V_FULL_NEG) &&
         (rsp_turn_rate == lss_pkg::V_FULL_POS || rsp_turn_rate == lss_pkg::V_FULL_NEG))
      else $error("recovery command out of set");

endmodule

bind lidar_sector_steering lss_checker u_lss_checker (.*);
